### src/nem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nem_pkg: shared types and constants for the noise envelope masker
// Word formats, configuration register indexes, reset values and the
// controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package nem_pkg;

	localparam int unsigned DATA_W   = 16;
	localparam int unsigned ENV_W    = 15;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [DATA_W-1:0] ATTACK_RESET  = 16'd3000;
	localparam logic [DATA_W-1:0] RELEASE_RESET = 16'd600;
	localparam logic [DATA_W-1:0] GAIN_RESET    = 16'd4096;

	localparam logic [ENV_W-1:0] ENV_MAX = 15'h7fff;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ATTACK  = 2'd0,
		CFG_RELEASE = 2'd1,
		CFG_GAIN    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample_in;
		logic signed [DATA_W-1:0] noise_in;
		logic                     in_last;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample_out;
		logic                     out_last;
	} out_t;

	typedef struct packed {
		logic load_in;   // capture the accepted input word
		logic do_env;    // coefficient times envelope error
		logic do_upd;    // update the envelope
		logic do_mod;    // noise times envelope
		logic do_gain;   // modulated noise times makeup gain
		logic load_out;  // shift toward zero, clip and load the output word
	} cmd_t;

endpackage

### src/nem_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nem_datapath: envelope follower and noise modulation arithmetic
// Holds the configuration registers, the envelope, the captured input word,
// one registered multiplier product per multiply step and the output payload.
// ----------------------------------------------------------------------------
module nem_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  nem_pkg::cmd_t            cmd,
	input  nem_pkg::in_t             in_data,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [15:0]              cfg_data,
	output nem_pkg::out_t            out_data
);

	logic [15:0]        attack_q;
	logic [15:0]        release_q;
	logic [15:0]        gain_q;
	logic [14:0]        env_q;

	nem_pkg::in_t       in_q;
	logic signed [33:0] err_prod_q;
	logic signed [31:0] mod_prod_q;
	logic signed [33:0] gain_prod_q;
	nem_pkg::out_t      out_q;

	logic signed [16:0] x_ext;
	logic        [16:0] mag;
	logic        [14:0] mag_sat;
	logic signed [16:0] err;
	logic        [15:0] coeff;
	logic signed [17:0] step;
	logic signed [17:0] env_sum;
	logic        [14:0] env_next;
	logic signed [16:0] mod_val;
	logic signed [33:0] rnd_sum;
	logic signed [21:0] quot;
	logic signed [15:0] clipped;

	// Envelope error and coefficient select
	always_comb begin
		x_ext   = {in_q.sample_in[15], in_q.sample_in};
		mag     = x_ext[16] ? 17'(-x_ext) : 17'(x_ext);
		mag_sat = (mag > 17'd32767) ? nem_pkg::ENV_MAX : mag[14:0];
		err     = $signed({2'b00, mag_sat}) - $signed({2'b00, env_q});
		coeff   = (mag_sat > env_q) ? attack_q : release_q;
	end

	// Envelope update: floor shift, then hold within range
	always_comb begin
		step    = err_prod_q[33:16];
		env_sum = $signed({3'b000, env_q}) + step;
		if (env_sum < 0) begin
			env_next = '0;
		end else if (env_sum > $signed({3'b000, nem_pkg::ENV_MAX})) begin
			env_next = nem_pkg::ENV_MAX;
		end else begin
			env_next = env_sum[14:0];
		end
	end

	// Output: shift toward zero, then clip symmetric
	always_comb begin
		mod_val = mod_prod_q[31:15];
		rnd_sum = gain_prod_q + (gain_prod_q[33] ? 34'sd4095 : 34'sd0);
		quot    = rnd_sum[33:12];
		if (quot > 22'sd32767) begin
			clipped = 16'sd32767;
		end else if (quot < -22'sd32767) begin
			clipped = -16'sd32767;
		end else begin
			clipped = quot[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= nem_pkg::ATTACK_RESET;
			release_q <= nem_pkg::RELEASE_RESET;
			gain_q    <= nem_pkg::GAIN_RESET;
			env_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					nem_pkg::CFG_ATTACK:  attack_q  <= cfg_data;
					nem_pkg::CFG_RELEASE: release_q <= cfg_data;
					nem_pkg::CFG_GAIN:    gain_q    <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.do_upd) begin
				env_q <= env_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= in_data;
		end
		if (cmd.do_env) begin
			err_prod_q <= $signed({1'b0, coeff}) * err;
		end
		if (cmd.do_mod) begin
			mod_prod_q <= in_q.noise_in * $signed({1'b0, env_q});
		end
		if (cmd.do_gain) begin
			gain_prod_q <= mod_val * $signed({1'b0, gain_q});
		end
		if (cmd.load_out) begin
			out_q.sample_out <= clipped;
			out_q.out_last   <= in_q.in_last;
		end
	end

	assign out_data = out_q;

	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= nem_pkg::ENV_MAX)
		else $error("envelope out of range");

	a_out_clip: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.load_out) |-> out_q.sample_out != 16'sh8000)
		else $error("output word not clipped");

endmodule

### src/nem_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nem_ctrl: step sequencer for the noise envelope masker
// Walks one word through the datapath steps and owns the output valid flag.
// ----------------------------------------------------------------------------
module nem_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output nem_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENV,
		S_UPD,
		S_MOD,
		S_GAIN,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load_in  = in_valid && (state_q == S_IDLE);
		cmd.do_env   = (state_q == S_ENV);
		cmd.do_upd   = (state_q == S_UPD);
		cmd.do_mod   = (state_q == S_MOD);
		cmd.do_gain  = (state_q == S_GAIN);
		cmd.load_out = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// raise valid on a new output word, drop it once the word is taken
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ENV;
					end
				end
				S_ENV:  state_q <= S_UPD;
				S_UPD:  state_q <= S_MOD;
				S_MOD:  state_q <= S_GAIN;
				S_GAIN: state_q <= S_DONE;
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new word taken while one is in flight");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("output loaded without valid");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("output valid raised outside the final step");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.do_env, cmd.do_upd, cmd.do_mod, cmd.do_gain, cmd.load_out}))
		else $error("more than one datapath step at once");

endmodule

### src/noise_envelope_masker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_envelope_masker: envelope-driven noise masker
// Follows the magnitude of an audio sample with an attack/release envelope
// and scales a noise sample by that envelope and a makeup gain.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one word: audio sample, noise
//   sample and an end-of-buffer flag. Output channel out_valid/out_ready
//   returns one word per input: the modulated, clipped noise and the flag.
//   Configuration channel cfg_valid/cfg_ready writes attack coefficient
//   (index 0), release coefficient (index 1) or makeup gain (index 2);
//   other indexes are ignored. cfg_ready is always high.
//   A single sequencer walks each word through five steps, three of them
//   multiplies with a registered product, and takes no new input until
//   the word has left its final step.
//   The next input is taken while a finished word still waits at the output
//   register; when the receiver stalls, the word after it holds in its final
//   step and in_ready stays low until the output register frees.
//   Reset clears the envelope to zero and loads the coefficient defaults
//   (3000, 600, 4096).
// ----------------------------------------------------------------------------
module noise_envelope_masker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  nem_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output nem_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);

	nem_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	nem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	nem_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule
